/* hw/rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent property sampled on the rising clock, off while reset is low
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same, written as antecedent and consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  `ASSERT_PROP(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

/* hw/rtl/fbct_pkg.sv */
// types and constants of the focus/break countdown timer
package fbct_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_TURN  = 2'd1,
    OP_PRESS = 2'd2,
    OP_RESET = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PH_SETTING = 2'd0,
    PH_RUNNING = 2'd1,
    PH_PAUSED  = 2'd2,
    PH_ALARM   = 2'd3
  } phase_e;

  localparam int unsigned MinW   = 7;
  localparam int unsigned SecW   = 6;
  localparam int unsigned MsW    = 10;
  localparam int unsigned AlarmW = 15;
  localparam int unsigned BlinkW = 11;

  localparam logic [MinW-1:0] MIN_MINUTES     = 7'd1;
  localparam logic [MinW-1:0] MAX_MINUTES     = 7'd99;
  localparam logic [MinW-1:0] FOCUS_RESET_MIN = 7'd25;
  localparam logic [MinW-1:0] BREAK_RESET_MIN = 7'd5;
  localparam logic [MinW-1:0] SHOW_MAX_MIN    = 7'd99;
  localparam logic [SecW-1:0] SHOW_MAX_SEC    = 6'd59;
  localparam logic [SecW-1:0] SEC_PER_MIN     = 6'd60;
  localparam logic [MsW-1:0]  MS_PER_SEC      = 10'd1000;

  localparam logic [AlarmW-1:0] ALARM_CAP_MS  = 15'd30000;
  localparam logic [BlinkW-1:0] BLINK_WRAP_MS = 11'd2000;

  typedef struct packed {
    logic [1:0]        operation;
    logic signed [3:0] turn_steps;
    logic [MsW-1:0]    elapsed_ms;
  } fbct_in_t;

  typedef struct packed {
    logic [1:0]      phase;
    logic            break_mode;
    logic [MinW-1:0] shown_minutes;
    logic [SecW-1:0] shown_seconds;
    logic            digits_hidden;
    logic            alarm_flash;
  } fbct_out_t;

endpackage

/* hw/rtl/focus_break_countdown_timer.sv */
// A request accepted into the input register moves on into the result register unless an output stall holds it.
// Throughput: one request per cycle unless the output stalls; the input register feeds one pass
//   of update logic into the result register, so back-to-back requests wait only on an output stall.
// in_stall_o rises only when the result register holds a result that the output stalls and the
//   input register is full.
// Reset (rst_ni low, asynchronous): setting phase, focus mode, 25/5 minutes, counters zero.
module focus_break_countdown_timer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fbct_pkg::fbct_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fbct_pkg::fbct_out_t out_data_o
);

  // remaining time is kept as minutes : seconds : milliseconds so the
  // display needs no division, only a ceiling round-up of the seconds
  localparam logic [fbct_pkg::BlinkW-1:0] BlinkHalfS  = 11'd500;
  localparam logic [fbct_pkg::BlinkW-1:0] BlinkOneS   = 11'd1000;
  localparam logic [fbct_pkg::BlinkW-1:0] BlinkOneS5  = 11'd1500;
  localparam logic [fbct_pkg::BlinkW-1:0] Flash200    = 11'd200;
  localparam logic [fbct_pkg::BlinkW-1:0] Flash400    = 11'd400;
  localparam logic [fbct_pkg::BlinkW-1:0] Flash600    = 11'd600;
  localparam logic [fbct_pkg::BlinkW-1:0] Flash800    = 11'd800;
  localparam logic [fbct_pkg::BlinkW-1:0] Flash1200   = 11'd1200;
  localparam logic [fbct_pkg::BlinkW-1:0] Flash1400   = 11'd1400;
  localparam logic [fbct_pkg::BlinkW-1:0] Flash1600   = 11'd1600;
  localparam logic [fbct_pkg::BlinkW-1:0] Flash1800   = 11'd1800;

  // ---------------------------------------------------------------------------
  // handshake: input register (stage 1) and result register (stage 2)
  // ---------------------------------------------------------------------------
  logic               s1_valid_q, s1_valid_d;
  fbct_pkg::fbct_in_t s1_item_q;
  logic               out_valid_q, out_valid_d;
  fbct_pkg::fbct_out_t out_data_q, res_d;
  logic               in_accept;
  logic               s1_fire;

  // the item in stage 1 moves on whenever the result slot is free or drains now
  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_data_i;
    end
    if (s1_fire) begin
      out_data_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // timer state
  // ---------------------------------------------------------------------------
  fbct_pkg::phase_e                phase_q, phase_d;
  logic                            mode_q, mode_d;
  logic [fbct_pkg::MinW-1:0]       focus_min_q, focus_min_d;
  logic [fbct_pkg::MinW-1:0]       break_min_q, break_min_d;
  logic [fbct_pkg::MinW-1:0]       rem_min_q, rem_min_d;
  logic [fbct_pkg::SecW-1:0]       rem_sec_q, rem_sec_d;
  logic [fbct_pkg::MsW-1:0]        rem_ms_q, rem_ms_d;
  logic [fbct_pkg::AlarmW-1:0]     alarm_ms_q, alarm_ms_d;
  logic [fbct_pkg::BlinkW-1:0]     blink_ms_q, blink_ms_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= fbct_pkg::PH_SETTING;
      mode_q      <= 1'b0;
      focus_min_q <= fbct_pkg::FOCUS_RESET_MIN;
      break_min_q <= fbct_pkg::BREAK_RESET_MIN;
      rem_min_q   <= '0;
      rem_sec_q   <= '0;
      rem_ms_q    <= '0;
      alarm_ms_q  <= '0;
      blink_ms_q  <= '0;
    end else if (s1_fire) begin
      phase_q     <= phase_d;
      mode_q      <= mode_d;
      focus_min_q <= focus_min_d;
      break_min_q <= break_min_d;
      rem_min_q   <= rem_min_d;
      rem_sec_q   <= rem_sec_d;
      rem_ms_q    <= rem_ms_d;
      alarm_ms_q  <= alarm_ms_d;
      blink_ms_q  <= blink_ms_d;
    end
  end

  // ---------------------------------------------------------------------------
  // event decode and state update
  // ---------------------------------------------------------------------------
  fbct_pkg::op_e              op;
  logic [fbct_pkg::MsW-1:0]   dt;

  // tick arithmetic
  logic [fbct_pkg::BlinkW:0]  blink_sum;
  logic                       dt_sec;       // elapsed reaches a whole second
  logic [fbct_pkg::MsW-1:0]   dt_ms;
  logic [fbct_pkg::MsW:0]     ms_diff;
  logic                       ms_borrow;
  logic [fbct_pkg::MsW-1:0]   ms_new;
  logic [fbct_pkg::SecW:0]    sec_diff;
  logic                       sec_borrow;
  logic [fbct_pkg::SecW-1:0]  sec_new;
  logic [fbct_pkg::MinW:0]    min_diff;
  logic                       run_out;      // countdown reaches or passes zero
  logic [fbct_pkg::AlarmW:0]  alarm_sum;

  // knob arithmetic, signed minutes
  logic [fbct_pkg::MinW-1:0]  cur_min;
  logic signed [fbct_pkg::MinW+1:0] knob_sum;
  logic signed [fbct_pkg::MinW+1:0] knob_lo;
  logic signed [fbct_pkg::MinW+1:0] knob_hi;
  logic [fbct_pkg::MinW-1:0]  knob_min;

  assign op = fbct_pkg::op_e'(s1_item_q.operation);
  assign dt = s1_item_q.elapsed_ms;

  // blink clock wraps at 2 s, a common multiple of both blink periods
  assign blink_sum = {1'b0, blink_ms_q} + {2'b00, dt};

  // split elapsed into whole seconds and leftover milliseconds
  assign dt_sec = (dt >= fbct_pkg::MS_PER_SEC);
  assign dt_ms  = dt_sec ? (dt - fbct_pkg::MS_PER_SEC) : dt;

  // mixed-radix borrow chain: ms -> s -> min
  assign ms_diff   = {1'b0, rem_ms_q} - {1'b0, dt_ms};
  assign ms_borrow = ms_diff[fbct_pkg::MsW];
  assign ms_new    = ms_borrow ? (ms_diff[fbct_pkg::MsW-1:0] + fbct_pkg::MS_PER_SEC)
                               : ms_diff[fbct_pkg::MsW-1:0];
  assign sec_diff   = {1'b0, rem_sec_q} - {{fbct_pkg::SecW{1'b0}}, dt_sec}
                      - {{fbct_pkg::SecW{1'b0}}, ms_borrow};
  assign sec_borrow = sec_diff[fbct_pkg::SecW];
  assign sec_new    = sec_borrow ? (sec_diff[fbct_pkg::SecW-1:0] + fbct_pkg::SEC_PER_MIN)
                                 : sec_diff[fbct_pkg::SecW-1:0];
  assign min_diff   = {1'b0, rem_min_q} - {{fbct_pkg::MinW{1'b0}}, sec_borrow};
  assign run_out    = min_diff[fbct_pkg::MinW] ||
                      ((min_diff == '0) && (sec_new == '0) && (ms_new == '0));

  assign alarm_sum = {1'b0, alarm_ms_q} + {{(fbct_pkg::AlarmW - fbct_pkg::MsW + 1){1'b0}}, dt};

  // knob adds signed minutes to the current mode's length, then clamps
  assign cur_min  = mode_q ? break_min_q : focus_min_q;
  assign knob_sum = $signed({2'b00, cur_min}) +
                    $signed({{(fbct_pkg::MinW - 2){s1_item_q.turn_steps[3]}},
                             s1_item_q.turn_steps});
  assign knob_lo  = $signed({2'b00, fbct_pkg::MIN_MINUTES});
  assign knob_hi  = $signed({2'b00, fbct_pkg::MAX_MINUTES});

  always_comb begin
    // lower clamp first, then upper clamp
    if (knob_sum < knob_lo) begin
      knob_min = fbct_pkg::MIN_MINUTES;
    end else if (knob_sum > knob_hi) begin
      knob_min = fbct_pkg::MAX_MINUTES;
    end else begin
      knob_min = knob_sum[fbct_pkg::MinW-1:0];
    end
    if (knob_min > fbct_pkg::MAX_MINUTES) begin
      knob_min = fbct_pkg::MAX_MINUTES;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    mode_d      = mode_q;
    focus_min_d = focus_min_q;
    break_min_d = break_min_q;
    rem_min_d   = rem_min_q;
    rem_sec_d   = rem_sec_q;
    rem_ms_d    = rem_ms_q;
    alarm_ms_d  = alarm_ms_q;
    blink_ms_d  = blink_ms_q;

    case (op)
      fbct_pkg::OP_TICK: begin
        if (blink_sum >= {1'b0, fbct_pkg::BLINK_WRAP_MS}) begin
          blink_ms_d = blink_sum[fbct_pkg::BlinkW-1:0] - fbct_pkg::BLINK_WRAP_MS;
        end else begin
          blink_ms_d = blink_sum[fbct_pkg::BlinkW-1:0];
        end
        if (phase_q == fbct_pkg::PH_RUNNING) begin
          if (run_out) begin
            // time past zero does not count as alarm time
            phase_d    = fbct_pkg::PH_ALARM;
            rem_min_d  = '0;
            rem_sec_d  = '0;
            rem_ms_d   = '0;
            alarm_ms_d = '0;
          end else begin
            rem_min_d = min_diff[fbct_pkg::MinW-1:0];
            rem_sec_d = sec_new;
            rem_ms_d  = ms_new;
          end
        end else if (phase_q == fbct_pkg::PH_ALARM) begin
          if (alarm_sum > {1'b0, fbct_pkg::ALARM_CAP_MS}) begin
            alarm_ms_d = fbct_pkg::ALARM_CAP_MS;
          end else begin
            alarm_ms_d = alarm_sum[fbct_pkg::AlarmW-1:0];
          end
        end
      end

      fbct_pkg::OP_TURN: begin
        if (phase_q == fbct_pkg::PH_SETTING) begin
          if (mode_q) begin
            break_min_d = knob_min;
          end else begin
            focus_min_d = knob_min;
          end
        end
      end

      fbct_pkg::OP_PRESS: begin
        case (phase_q)
          fbct_pkg::PH_SETTING: begin
            if (!mode_q) begin
              mode_d = 1'b1;
            end else begin
              // set break length done, start the focus run
              mode_d     = 1'b0;
              phase_d    = fbct_pkg::PH_RUNNING;
              rem_min_d  = focus_min_q;
              rem_sec_d  = '0;
              rem_ms_d   = '0;
              alarm_ms_d = '0;
            end
          end
          fbct_pkg::PH_RUNNING: begin
            phase_d = fbct_pkg::PH_PAUSED;
          end
          fbct_pkg::PH_PAUSED: begin
            phase_d = fbct_pkg::PH_RUNNING;
          end
          default: begin
            // alarm acknowledged: run the other mode
            mode_d     = !mode_q;
            phase_d    = fbct_pkg::PH_RUNNING;
            rem_min_d  = mode_q ? focus_min_q : break_min_q;
            rem_sec_d  = '0;
            rem_ms_d   = '0;
            alarm_ms_d = '0;
          end
        endcase
      end

      default: begin
        // long press: back to setting focus, lengths and blink clock kept
        mode_d     = 1'b0;
        phase_d    = fbct_pkg::PH_SETTING;
        rem_min_d  = '0;
        rem_sec_d  = '0;
        rem_ms_d   = '0;
        alarm_ms_d = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // display of the state after this request
  // ---------------------------------------------------------------------------
  logic [fbct_pkg::MinW-1:0] show_min;
  logic [fbct_pkg::SecW-1:0] show_sec;
  logic                      blink_half;
  logic                      blink_flash;

  always_comb begin
    if (phase_d == fbct_pkg::PH_SETTING) begin
      show_min = mode_d ? break_min_d : focus_min_d;
      show_sec = '0;
    end else if (rem_ms_d != '0) begin
      // round a partial second up
      if (rem_sec_d == fbct_pkg::SEC_PER_MIN - 6'd1) begin
        show_min = rem_min_d + 7'd1;
        show_sec = '0;
      end else begin
        show_min = rem_min_d;
        show_sec = rem_sec_d + 6'd1;
      end
    end else begin
      show_min = rem_min_d;
      show_sec = rem_sec_d;
    end
    if (show_min > fbct_pkg::SHOW_MAX_MIN) begin
      show_min = fbct_pkg::SHOW_MAX_MIN;
      show_sec = fbct_pkg::SHOW_MAX_SEC;
    end
  end

  // first half of each 1 s blink period
  assign blink_half = (blink_ms_d < BlinkHalfS) ||
                      ((blink_ms_d >= BlinkOneS) && (blink_ms_d < BlinkOneS5));
  // first 200 ms of each 400 ms flash period
  assign blink_flash = (blink_ms_d < Flash200) ||
                       ((blink_ms_d >= Flash400)  && (blink_ms_d < Flash600))  ||
                       ((blink_ms_d >= Flash800)  && (blink_ms_d < BlinkOneS)) ||
                       ((blink_ms_d >= Flash1200) && (blink_ms_d < Flash1400)) ||
                       ((blink_ms_d >= Flash1600) && (blink_ms_d < Flash1800));

  always_comb begin
    res_d.phase         = phase_d;
    res_d.break_mode    = mode_d;
    res_d.shown_minutes = show_min;
    res_d.shown_seconds = show_sec;
    res_d.digits_hidden = (phase_d == fbct_pkg::PH_PAUSED) && blink_half;
    res_d.alarm_flash   = (phase_d == fbct_pkg::PH_ALARM) &&
                          (alarm_ms_d < fbct_pkg::ALARM_CAP_MS) && blink_flash;
  end

endmodule

/* hw/rtl/fbct_checker.sv */
// port-level assertions for the countdown timer, bound to the top level
`include "assert_macros.svh"

module fbct_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input fbct_pkg::fbct_out_t out_data_o
);

  // a stalled result stays put
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")

  // shown time never leaves 99:59
  `ASSERT_IMPLIES(a_time_range, clk_i, rst_ni, out_valid_o, (out_data_o.shown_seconds < 6'd60) && (out_data_o.shown_minutes <= fbct_pkg::SHOW_MAX_MIN), "shown time out of range")

  // blink flags only in their own phase
  `ASSERT_IMPLIES(a_flag_phase, clk_i, rst_ni, out_valid_o && (out_data_o.digits_hidden || out_data_o.alarm_flash), (out_data_o.digits_hidden && out_data_o.phase == fbct_pkg::PH_PAUSED && !out_data_o.alarm_flash) || (out_data_o.alarm_flash && out_data_o.phase == fbct_pkg::PH_ALARM && !out_data_o.digits_hidden), "blink flag in wrong phase")

  // setting shows whole minutes of at least the minimum length
  `ASSERT_IMPLIES(a_setting_show, clk_i, rst_ni, out_valid_o && out_data_o.phase == fbct_pkg::PH_SETTING, (out_data_o.shown_seconds == 6'd0) && (out_data_o.shown_minutes >= fbct_pkg::MIN_MINUTES), "setting shows partial minutes")

endmodule

bind focus_break_countdown_timer fbct_checker u_fbct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
